>>> rtl/tbw_pkg.sv
`default_nettype none

package tbw_pkg;

	// fixed formats
	localparam int CRD_W  = 32;          // corner and point coordinates
	localparam int DIF_W  = CRD_W + 1;   // edge and offset vectors
	localparam int PRD_W  = 2 * DIF_W;   // one term of a dot product
	localparam int D_W    = PRD_W + 2;   // dot product (three terms)
	localparam int P_W    = 2 * D_W;     // product of two dot products
	localparam int N_W    = P_W + 2;     // determinant and numerators
	localparam int QB     = 33;          // quotient magnitude bits
	localparam int STEP_W = 31;
	localparam int WGT_W  = 32;

	localparam logic [STEP_W-1:0] STEP_RESET = 31'd167772;

	localparam logic signed [WGT_W-1:0] W_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [WGT_W-1:0] W_MIN = 32'sh8000_0000;

	// per-item flags that ride along the divider stages
	typedef struct packed {
		logic       deg;
		logic [2:0] neg;
		logic [2:0] ovf;
	} tbw_side_t;

endpackage

`default_nettype wire

>>> rtl/tbw_mul.sv
`default_nettype none

module tbw_mul (
	input  wire logic                             clk,
	input  wire logic                             en_a,
	input  wire logic                             en_b,
	input  wire logic signed [tbw_pkg::D_W-1:0]   a,
	input  wire logic signed [tbw_pkg::D_W-1:0]   b,
	output logic signed [tbw_pkg::P_W-1:0]        prod
);

	localparam int DW = tbw_pkg::D_W;
	localparam int PW = tbw_pkg::P_W;
	localparam int H  = DW / 2;
	localparam int HW = DW - H;

	logic signed [HW-1:0]     a_hi, b_hi;
	logic signed [H:0]        a_lo, b_lo;
	logic signed [2*HW-1:0]   hh_s4;
	logic signed [DW:0]       hl_s4, lh_s4;
	logic signed [2*H+1:0]    ll_s4;
	logic signed [DW+1:0]     mid;

	// signed upper half, unsigned lower half
	assign a_hi = a[DW-1:H];
	assign b_hi = b[DW-1:H];
	assign a_lo = {1'b0, a[H-1:0]};
	assign b_lo = {1'b0, b[H-1:0]};

	always_ff @(posedge clk) begin
		if (en_a) begin
			hh_s4 <= a_hi * b_hi;
			hl_s4 <= a_hi * b_lo;
			lh_s4 <= a_lo * b_hi;
			ll_s4 <= a_lo * b_lo;
		end
	end

	assign mid = hl_s4 + lh_s4;

	always_ff @(posedge clk) begin
		if (en_b) begin
			prod <= (PW'(hh_s4) << (2 * H)) + (PW'(mid) << H) + PW'(ll_s4);
		end
	end

endmodule

`default_nettype wire

>>> rtl/tbw_div.sv
`default_nettype none

module tbw_div #(
	parameter int R_W = 200
) (
	input  wire logic                         clk,
	input  wire logic [tbw_pkg::QB-1:0]       en,
	input  wire logic [R_W-1:0]               num,
	input  wire logic [tbw_pkg::N_W-1:0]      den,
	output logic [tbw_pkg::QB-1:0]            quo,
	output logic                              rem_nz
);

	localparam int QB = tbw_pkg::QB;
	localparam int NW = tbw_pkg::N_W;

	logic [R_W-1:0] rem_s [QB];
	logic [QB-1:0]  quo_s [QB];
	logic [NW-1:0]  den_s [QB];

	logic [R_W-1:0] rem_in [QB];
	logic [QB-1:0]  quo_in [QB];
	logic [NW-1:0]  den_in [QB];
	logic [R_W-1:0] rem_nx [QB];
	logic [QB-1:0]  quo_nx [QB];

	// restoring division, one quotient bit per stage, msb first
	always_comb begin
		logic [R_W-1:0] d_sh;
		logic [R_W:0]   diff;
		rem_in[0] = num;
		quo_in[0] = '0;
		den_in[0] = den;
		for (int k = 1; k < QB; k++) begin
			rem_in[k] = rem_s[k-1];
			quo_in[k] = quo_s[k-1];
			den_in[k] = den_s[k-1];
		end
		for (int k = 0; k < QB; k++) begin
			d_sh = R_W'(den_in[k]) << (QB - 1 - k);
			diff = {1'b0, rem_in[k]} - {1'b0, d_sh};
			rem_nx[k] = diff[R_W] ? rem_in[k] : diff[R_W-1:0];
			quo_nx[k] = quo_in[k] | (QB'(!diff[R_W]) << (QB - 1 - k));
		end
	end

	always_ff @(posedge clk) begin
		for (int k = 0; k < QB; k++) begin
			if (en[k]) begin
				rem_s[k] <= rem_nx[k];
				quo_s[k] <= quo_nx[k];
				den_s[k] <= den_in[k];
			end
		end
	end

	assign quo    = quo_s[QB-1];
	assign rem_nz = |rem_s[QB-1];

endmodule

`default_nettype wire

>>> rtl/triangle_barycentric_weights_core.sv
`default_nettype none

// barycentric weights of a query point against a triangle
// input channel (in_valid / in_ready): three corners and the point, signed fixed point;
//   a transfer happens when both are high
// output channel (out_valid / out_ready): weight0..2 in signed fixed point with
//   WEIGHT_FRAC_BITS fraction bits, rounded to nearest and saturated, plus legal
//   and degenerate flags
// config: cfg_we writes cfg_wdata into weight_step in the same edge; write it only
//   while no item is in flight
// pipeline: after the input transfer the result passes these register stages:
//   10 for edges, dot products, split 68x68 multiplies and the determinant,
//   33 for the bit-per-stage restoring divider, 2 for rounding and range check
// throughput: one item per cycle unless stalled; every stage holds its own valid bit
// stall: when out_ready is low the result holds and stages behind it keep
//   filling empty slots; in_ready drops only once every stage is occupied
// reset: arst_n clears all valid bits and loads weight_step with its default;
//   the pipeline payload is not cleared
module triangle_barycentric_weights_core #(
	parameter int WEIGHT_FRAC_BITS = 24
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [tbw_pkg::STEP_W-1:0]          cfg_wdata,
	input  wire logic                                in_valid,
	output logic                                     in_ready,
	input  wire logic signed [tbw_pkg::CRD_W-1:0]    corner0_x,
	input  wire logic signed [tbw_pkg::CRD_W-1:0]    corner0_y,
	input  wire logic signed [tbw_pkg::CRD_W-1:0]    corner0_z,
	input  wire logic signed [tbw_pkg::CRD_W-1:0]    corner1_x,
	input  wire logic signed [tbw_pkg::CRD_W-1:0]    corner1_y,
	input  wire logic signed [tbw_pkg::CRD_W-1:0]    corner1_z,
	input  wire logic signed [tbw_pkg::CRD_W-1:0]    corner2_x,
	input  wire logic signed [tbw_pkg::CRD_W-1:0]    corner2_y,
	input  wire logic signed [tbw_pkg::CRD_W-1:0]    corner2_z,
	input  wire logic signed [tbw_pkg::CRD_W-1:0]    point_x,
	input  wire logic signed [tbw_pkg::CRD_W-1:0]    point_y,
	input  wire logic signed [tbw_pkg::CRD_W-1:0]    point_z,
	output logic                                     out_valid,
	input  wire logic                                out_ready,
	output logic signed [tbw_pkg::WGT_W-1:0]         weight0,
	output logic signed [tbw_pkg::WGT_W-1:0]         weight1,
	output logic signed [tbw_pkg::WGT_W-1:0]         weight2,
	output logic                                     legal,
	output logic                                     degenerate
);

	localparam int DFW = tbw_pkg::DIF_W;
	localparam int PRW = tbw_pkg::PRD_W;
	localparam int DW  = tbw_pkg::D_W;
	localparam int PW  = tbw_pkg::P_W;
	localparam int NW  = tbw_pkg::N_W;
	localparam int QB  = tbw_pkg::QB;
	localparam int SW  = tbw_pkg::STEP_W;
	localparam int WW  = tbw_pkg::WGT_W;
	localparam int XW  = NW + WEIGHT_FRAC_BITS + 2;   // shifted numerator plus det
	localparam int R_W = XW + QB;                     // divider remainder width
	localparam int VW  = QB + 2;                      // signed quotient before saturation
	localparam int LW  = SW + 3;                      // range check width

	// stage map
	localparam int ST_DIV0 = 11;
	localparam int ST_F1   = ST_DIV0 + QB;
	localparam int NS      = ST_F1 + 1;

	localparam logic signed [LW-1:0] ONE_W = LW'(1) << WEIGHT_FRAC_BITS;

	// ---------------------------------------------------------------
	// handshake: each stage advances when it is empty or the next one moves
	// ---------------------------------------------------------------
	logic [NS+1:1] en;
	logic [NS:1]   vld_q;
	logic [NS:1]   vld_nx;

	assign en[NS+1]  = out_ready;
	assign en[NS:1]  = ~vld_q | en[NS+1:2];
	assign vld_nx    = {vld_q[NS-1:1], in_valid};
	assign in_ready  = en[1];
	assign out_valid = vld_q[NS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int k = 1; k <= NS; k++) begin
				if (en[k]) begin
					vld_q[k] <= vld_nx[k];
				end
			end
		end
	end

	// ---------------------------------------------------------------
	// tolerance register
	// ---------------------------------------------------------------
	logic [SW-1:0] weight_step_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			weight_step_q <= tbw_pkg::STEP_RESET;
		end else if (cfg_we) begin
			weight_step_q <= cfg_wdata;
		end
	end

	// ---------------------------------------------------------------
	// stage 1: edge vectors u01, u02 and point offset p - c0
	// ---------------------------------------------------------------
	logic signed [tbw_pkg::CRD_W-1:0] c0 [3], c1 [3], c2 [3], pt [3];
	logic signed [DFW-1:0] u01_s1 [3], u02_s1 [3], pc_s1 [3];

	assign c0[0] = corner0_x;
	assign c0[1] = corner0_y;
	assign c0[2] = corner0_z;
	assign c1[0] = corner1_x;
	assign c1[1] = corner1_y;
	assign c1[2] = corner1_z;
	assign c2[0] = corner2_x;
	assign c2[1] = corner2_y;
	assign c2[2] = corner2_z;
	assign pt[0] = point_x;
	assign pt[1] = point_y;
	assign pt[2] = point_z;

	always_ff @(posedge clk) begin
		if (en[1]) begin
			for (int j = 0; j < 3; j++) begin
				u01_s1[j] <= DFW'(c1[j]) - DFW'(c0[j]);
				u02_s1[j] <= DFW'(c2[j]) - DFW'(c0[j]);
				pc_s1[j]  <= DFW'(pt[j]) - DFW'(c0[j]);
			end
		end
	end

	// ---------------------------------------------------------------
	// stage 2: the fifteen per-axis products
	// ---------------------------------------------------------------
	logic signed [PRW-1:0] t00_s2 [3], t01_s2 [3], t11_s2 [3], te0_s2 [3], te1_s2 [3];

	always_ff @(posedge clk) begin
		if (en[2]) begin
			for (int j = 0; j < 3; j++) begin
				t00_s2[j] <= u01_s1[j] * u01_s1[j];
				t01_s2[j] <= u01_s1[j] * u02_s1[j];
				t11_s2[j] <= u02_s1[j] * u02_s1[j];
				te0_s2[j] <= u01_s1[j] * pc_s1[j];
				te1_s2[j] <= u02_s1[j] * pc_s1[j];
			end
		end
	end

	// ---------------------------------------------------------------
	// stage 3: gram entries and right-hand side
	// ---------------------------------------------------------------
	logic signed [DW-1:0] d00_s3, d01_s3, d11_s3, e0_s3, e1_s3;

	always_ff @(posedge clk) begin
		if (en[3]) begin
			d00_s3 <= DW'(t00_s2[0]) + DW'(t00_s2[1]) + DW'(t00_s2[2]);
			d01_s3 <= DW'(t01_s2[0]) + DW'(t01_s2[1]) + DW'(t01_s2[2]);
			d11_s3 <= DW'(t11_s2[0]) + DW'(t11_s2[1]) + DW'(t11_s2[2]);
			e0_s3  <= DW'(te0_s2[0]) + DW'(te0_s2[1]) + DW'(te0_s2[2]);
			e1_s3  <= DW'(te1_s2[0]) + DW'(te1_s2[1]) + DW'(te1_s2[2]);
		end
	end

	// ---------------------------------------------------------------
	// stages 4-5: six wide products, each split into four partials
	// ---------------------------------------------------------------
	logic signed [DW-1:0] mul_a [6], mul_b [6];
	logic signed [PW-1:0] prod_s5 [6];

	assign mul_a[0] = d00_s3;  assign mul_b[0] = d11_s3;   // det terms
	assign mul_a[1] = d01_s3;  assign mul_b[1] = d01_s3;
	assign mul_a[2] = d11_s3;  assign mul_b[2] = e0_s3;    // n1 terms
	assign mul_a[3] = d01_s3;  assign mul_b[3] = e1_s3;
	assign mul_a[4] = d00_s3;  assign mul_b[4] = e1_s3;    // n2 terms
	assign mul_a[5] = d01_s3;  assign mul_b[5] = e0_s3;

	for (genvar m = 0; m < 6; m++) begin : g_mul
		tbw_mul u_mul (
			.clk  (clk),
			.en_a (en[4]),
			.en_b (en[5]),
			.a    (mul_a[m]),
			.b    (mul_b[m]),
			.prod (prod_s5[m])
		);
	end

	// ---------------------------------------------------------------
	// stage 6: determinant and cramer numerators
	// ---------------------------------------------------------------
	logic signed [NW-1:0] det_s6, n1_s6, n2_s6;

	always_ff @(posedge clk) begin
		if (en[6]) begin
			det_s6 <= NW'(prod_s5[0]) - NW'(prod_s5[1]);
			n1_s6  <= NW'(prod_s5[2]) - NW'(prod_s5[3]);
			n2_s6  <= NW'(prod_s5[4]) - NW'(prod_s5[5]);
		end
	end

	// ---------------------------------------------------------------
	// stage 7: make the determinant non-negative
	// ---------------------------------------------------------------
	logic signed [NW-1:0] det_s7, n1_s7, n2_s7;

	always_ff @(posedge clk) begin
		if (en[7]) begin
			det_s7 <= det_s6[NW-1] ? -det_s6 : det_s6;
			n1_s7  <= det_s6[NW-1] ? -n1_s6  : n1_s6;
			n2_s7  <= det_s6[NW-1] ? -n2_s6  : n2_s6;
		end
	end

	// ---------------------------------------------------------------
	// stage 8: n0 = det - n1 - n2, degenerate flag
	// ---------------------------------------------------------------
	logic signed [NW-1:0] det_s8;
	logic signed [NW-1:0] num_s8 [3];
	logic                 deg_s8;

	always_ff @(posedge clk) begin
		if (en[8]) begin
			det_s8    <= det_s7;
			num_s8[0] <= det_s7 - n1_s7 - n2_s7;
			num_s8[1] <= n1_s7;
			num_s8[2] <= n2_s7;
			deg_s8    <= (det_s7 == '0);
		end
	end

	// ---------------------------------------------------------------
	// stage 9: x = n * 2^(frac+1) + det, so that floor(x / 2det) rounds n / det
	// ---------------------------------------------------------------
	logic signed [XW-1:0] x_s9 [3];
	logic signed [NW-1:0] det_s9;
	logic                 deg_s9;

	always_ff @(posedge clk) begin
		if (en[9]) begin
			for (int j = 0; j < 3; j++) begin
				x_s9[j] <= (XW'(num_s8[j]) << (WEIGHT_FRAC_BITS + 1)) + XW'(det_s8);
			end
			det_s9 <= det_s8;
			deg_s9 <= deg_s8;
		end
	end

	// ---------------------------------------------------------------
	// stage 10: magnitude and sign of x, divisor 2det
	// ---------------------------------------------------------------
	logic [XW-1:0] mag_s10 [3];
	logic [2:0]    neg_s10;
	logic [NW-1:0] dd_s10;
	logic          deg_s10;

	always_ff @(posedge clk) begin
		if (en[10]) begin
			for (int j = 0; j < 3; j++) begin
				neg_s10[j] <= x_s9[j][XW-1];
				mag_s10[j] <= x_s9[j][XW-1] ? XW'(-x_s9[j]) : XW'(x_s9[j]);
			end
			dd_s10  <= {det_s9[NW-2:0], 1'b0};
			deg_s10 <= deg_s9;
		end
	end

	// ---------------------------------------------------------------
	// stages 11-43: three dividers, flags ride alongside
	// ---------------------------------------------------------------
	logic [QB-1:0]       quo [3];
	logic [2:0]          rnz;
	logic [2:0]          ovf;
	tbw_pkg::tbw_side_t  side_s [QB];

	// a quotient of 2^QB or more saturates whatever the sign
	always_comb begin
		for (int j = 0; j < 3; j++) begin
			ovf[j] = R_W'(mag_s10[j]) >= (R_W'(dd_s10) << QB);
		end
	end

	for (genvar j = 0; j < 3; j++) begin : g_div
		tbw_div #(
			.R_W (R_W)
		) u_div (
			.clk    (clk),
			.en     (en[ST_DIV0+QB-1:ST_DIV0]),
			.num    (R_W'(mag_s10[j])),
			.den    (dd_s10),
			.quo    (quo[j]),
			.rem_nz (rnz[j])
		);
	end

	always_ff @(posedge clk) begin
		if (en[ST_DIV0]) begin
			side_s[0] <= '{deg: deg_s10, neg: neg_s10, ovf: ovf};
		end
		for (int k = 1; k < QB; k++) begin
			if (en[ST_DIV0+k]) begin
				side_s[k] <= side_s[k-1];
			end
		end
	end

	// ---------------------------------------------------------------
	// stage 44: floor of the signed quotient, saturate to the weight format
	// ---------------------------------------------------------------
	tbw_pkg::tbw_side_t side_d;
	logic signed [VW-1:0] qv [3];
	logic signed [WW-1:0] w_nx [3];
	logic signed [WW-1:0] w_s44 [3];
	logic                 deg_s44;

	assign side_d = side_s[QB-1];

	always_comb begin
		for (int j = 0; j < 3; j++) begin
			qv[j] = $signed({2'b00, quo[j]});
			if (side_d.neg[j]) begin
				// floor toward minus infinity when the remainder is not zero
				qv[j] = -qv[j] - $signed(VW'(rnz[j]));
			end
			if (side_d.deg) begin
				w_nx[j] = '0;
			end else if (side_d.ovf[j]) begin
				w_nx[j] = side_d.neg[j] ? tbw_pkg::W_MIN : tbw_pkg::W_MAX;
			end else if ((qv[j][VW-1:WW-1] == '0) || (qv[j][VW-1:WW-1] == '1)) begin
				w_nx[j] = qv[j][WW-1:0];
			end else begin
				w_nx[j] = qv[j][VW-1] ? tbw_pkg::W_MIN : tbw_pkg::W_MAX;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[ST_F1]) begin
			w_s44   <= w_nx;
			deg_s44 <= side_d.deg;
		end
	end

	// ---------------------------------------------------------------
	// stage 45: range check against [-step, 1 + step], output register
	// ---------------------------------------------------------------
	logic signed [LW-1:0] lo_b, hi_b;
	logic                 legal_nx;
	logic signed [WW-1:0] w_s45 [3];
	logic                 legal_s45, deg_s45;

	assign lo_b = -$signed({3'b000, weight_step_q});
	assign hi_b = $signed({3'b000, weight_step_q}) + ONE_W;

	always_comb begin
		legal_nx = !deg_s44;
		for (int j = 0; j < 3; j++) begin
			if ((LW'(w_s44[j]) < lo_b) || (LW'(w_s44[j]) > hi_b)) begin
				legal_nx = 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[NS]) begin
			w_s45     <= w_s44;
			legal_s45 <= legal_nx;
			deg_s45   <= deg_s44;
		end
	end

	assign weight0    = w_s45[0];
	assign weight1    = w_s45[1];
	assign weight2    = w_s45[2];
	assign legal      = legal_s45;
	assign degenerate = deg_s45;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	a_ready_follows: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("in_ready low while the receiver takes results");

	a_degenerate_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && degenerate |->
			weight0 == '0 && weight1 == '0 && weight2 == '0 && !legal)
		else $error("degenerate result with nonzero weights or legal set");

	a_legal_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && legal |->
			LW'(weight0) >= lo_b && LW'(weight0) <= hi_b &&
			LW'(weight1) >= lo_b && LW'(weight1) <= hi_b &&
			LW'(weight2) >= lo_b && LW'(weight2) <= hi_b)
		else $error("legal flag set with a weight out of range");

endmodule

`default_nettype wire
